@@ sv/scd1_pkg.sv @@
// Package: constants and character tables for the set-1 scan code decoder.
package scd1_pkg;

  localparam int unsigned KEY_MAP_DEPTH_DEF  = 256;
  localparam int unsigned MAX_ALT_DIGITS_DEF = 3;

  localparam logic [7:0] CODE_PREFIX  = 8'hE0;
  localparam logic [6:0] CODE_CTRL    = 7'h1D;
  localparam logic [6:0] CODE_ALT     = 7'h38;
  localparam logic [6:0] CODE_LSHIFT  = 7'h2A;
  localparam logic [6:0] CODE_RSHIFT  = 7'h36;
  localparam logic [6:0] CODE_CAPS    = 7'h3A;
  localparam logic [6:0] CODE_NUM     = 7'h45;
  localparam logic [6:0] CODE_SCROLL  = 7'h46;
  localparam logic [6:0] CODE_KP_LO   = 7'h47;
  localparam logic [6:0] CODE_KP_HI   = 7'h52;
  localparam logic [7:0] EXT_OFFSET   = 8'd127;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  localparam int unsigned M_LSHIFT = 0;
  localparam int unsigned M_RSHIFT = 1;
  localparam int unsigned M_LCTRL  = 2;
  localparam int unsigned M_RCTRL  = 3;
  localparam int unsigned M_LALT   = 4;
  localparam int unsigned M_RALT   = 5;

  localparam logic OP_SCAN  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [7:0] MAP_PLAIN [128] = '{
    8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D,
    8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60,
    8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F,
    8'h00, 8'h2A, 8'h00, 8'h20, 8'h00,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h00, 8'h00,
    8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h8A, 8'h8B,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] MAP_SHIFT [128] = '{
    8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
    8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D,
    8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h7E,
    8'h00, 8'h7C,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F,
    8'h00, 8'h2A, 8'h00, 8'h20, 8'h00,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h00, 8'h00,
    8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h8A, 8'h8B,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] MAP_CTRL [128] = '{
    8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
    8'h11, 8'h17, 8'h05, 8'h12, 8'h14, 8'h19, 8'h15, 8'h09, 8'h0F, 8'h10, 8'h5B, 8'h5D,
    8'h0D, 8'h00,
    8'h01, 8'h13, 8'h04, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0B, 8'h0C, 8'h3B, 8'h27, 8'h60,
    8'h00, 8'h5C,
    8'h1A, 8'h18, 8'h03, 8'h16, 8'h02, 8'h0E, 8'h0D, 8'h2C, 8'h2E, 8'h2F,
    8'h00, 8'h2A, 8'h00, 8'h20, 8'h00,
    8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8A, 8'h00,
    8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31, 8'h32, 8'h33,
    8'h30, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h8A, 8'h8B,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] map_ext(input logic [6:0] t);
    logic [7:0] c;
    case (t)
      7'd27:   c = 8'h0A;
      7'd52:   c = 8'h2F;
      7'd70:   c = 8'h90;
      7'd71:   c = 8'h8C;
      7'd72:   c = 8'h92;
      7'd74:   c = 8'h8D;
      7'd76:   c = 8'h8E;
      7'd78:   c = 8'h91;
      7'd79:   c = 8'h8F;
      7'd80:   c = 8'h93;
      7'd81:   c = 8'h94;
      7'd82:   c = 8'h7F;
      7'd90:   c = 8'h95;
      7'd91:   c = 8'h96;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/scan_code_set1_decoder_top.sv @@
// Set-1 scan code decoder: modifier and lock tracking, char maps, key-down map.
// Result: registered, valid the cycle after acceptance; one word per cycle while
// the output does not stall. The key-down RAM is written in the accept cycle and
// read there for queries, so consecutive words never collide on an entry.
// Reset: asynchronous, clears locks (num lock set), modifiers, alt entry and the
// per-entry valid bits of the key-down map, which then reads all zero at once.
module scan_code_set1_decoder_top #(
  parameter int unsigned KEY_MAP_DEPTH  = scd1_pkg::KEY_MAP_DEPTH_DEF,
  parameter int unsigned MAX_ALT_DIGITS = scd1_pkg::MAX_ALT_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] scan_byte_i,
  input  logic [7:0] key_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_code_o,
  output logic       alt_entry_done_o,
  output logic       led_update_o,
  output logic [2:0] led_mask_o,
  output logic       key_is_down_o
);
  import scd1_pkg::*;

  localparam int unsigned AW = $clog2(KEY_MAP_DEPTH);

  logic       accept;
  logic       caps_q, caps_d, num_q, num_d, scroll_q, scroll_d;
  logic [5:0] mod_q, mod_d;
  logic       ext_q, ext_d;
  logic [9:0] alt_q, alt_d;
  logic [1:0] cnt_q, cnt_d;

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] ch_q, ch_d;
  logic       altdone_q, altdone_d;
  logic       led_q, led_d;
  logic       query_q;
  logic       vld_rd_q;

  logic [KEY_MAP_DEPTH-1:0] vld_q;
  logic          wr_c, wdata_c;
  logic [7:0]    waddr_c;
  logic          rdata;

  logic [6:0]  code, t;
  logic        kp, ext_now, shift_c;
  logic [7:0]  dig_c;
  logic [12:0] alt_mul;

  assign in_stall_o = s1_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign s1_valid_d = accept | (s1_valid_q & out_stall_i);

  assign code    = scan_byte_i[6:0];
  assign t       = code - 7'd1;
  assign kp      = (code >= CODE_KP_LO) && (code <= CODE_KP_HI);
  assign ext_now = ext_q | (~num_q & kp);
  assign shift_c = mod_q[M_LSHIFT] | mod_q[M_RSHIFT];
  assign dig_c   = MAP_PLAIN[t] - CHAR_ZERO;
  assign alt_mul = {alt_q, 3'b000} + {2'b00, alt_q, 1'b0} + {9'd0, dig_c[3:0]};

  always_comb begin
    caps_d = caps_q; num_d = num_q; scroll_d = scroll_q;
    mod_d = mod_q; ext_d = ext_q; alt_d = alt_q; cnt_d = cnt_q;
    ch_d = 8'h00; altdone_d = 1'b0; led_d = 1'b0;
    wr_c = 1'b0; wdata_c = 1'b0; waddr_c = 8'h00;
    if (operation_i == OP_QUERY) begin
    end else if (scan_byte_i == CODE_PREFIX) begin
      ext_d = 1'b1;
    end else if (scan_byte_i == 8'h00) begin
    end else if (!scan_byte_i[7]) begin
      if (ext_now) begin
        ext_d = 1'b0;
        if (code == CODE_CTRL) begin
          mod_d[M_RCTRL] = 1'b1;
        end else if (code == CODE_ALT) begin
          mod_d[M_RALT] = 1'b1;
        end else begin
          ch_d = map_ext(t);
          wr_c = 1'b1; wdata_c = 1'b1; waddr_c = {1'b0, code} + EXT_OFFSET;
        end
      end else if (code == CODE_CTRL) begin
        mod_d[M_LCTRL] = 1'b1;
      end else if (code == CODE_LSHIFT) begin
        mod_d[M_LSHIFT] = 1'b1;
      end else if (code == CODE_RSHIFT) begin
        mod_d[M_RSHIFT] = 1'b1;
      end else if (code == CODE_ALT) begin
        mod_d[M_LALT] = 1'b1;
      end else if (code == CODE_CAPS) begin
        caps_d = ~caps_q; led_d = 1'b1;
      end else if (code == CODE_NUM) begin
        num_d = ~num_q; led_d = 1'b1;
      end else if (code == CODE_SCROLL) begin
        scroll_d = ~scroll_q; led_d = 1'b1;
      end else if (mod_q[M_LALT] | mod_q[M_RALT]) begin
        if (MAP_PLAIN[t] >= CHAR_ZERO && MAP_PLAIN[t] <= CHAR_NINE &&
            cnt_q < 2'(MAX_ALT_DIGITS) && kp) begin
          alt_d = alt_mul[9:0];
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        if (mod_q[M_LCTRL] | mod_q[M_RCTRL]) begin
          ch_d = MAP_CTRL[t];
        end else if (shift_c != caps_q) begin
          ch_d = MAP_SHIFT[t];
        end else begin
          ch_d = MAP_PLAIN[t];
        end
        wr_c = 1'b1; wdata_c = 1'b1; waddr_c = {1'b0, t};
      end
    end else begin
      if (ext_now) begin
        ext_d = 1'b0;
        if (code == CODE_CTRL) begin
          mod_d[M_RCTRL] = 1'b0;
        end else if (code == CODE_ALT) begin
          mod_d[M_RALT] = 1'b0;
        end else if (code != 7'd0) begin
          wr_c = 1'b1; waddr_c = {1'b0, code} + EXT_OFFSET;
        end
      end else if (code == CODE_CTRL) begin
        mod_d[M_LCTRL] = 1'b0;
      end else if (code == CODE_LSHIFT) begin
        mod_d[M_LSHIFT] = 1'b0;
      end else if (code == CODE_RSHIFT) begin
        mod_d[M_RSHIFT] = 1'b0;
      end else if (code == CODE_ALT) begin
        mod_d[M_LALT] = 1'b0;
      end else if (code == CODE_CAPS || code == CODE_NUM || code == CODE_SCROLL) begin
      end else if (code != 7'd0) begin
        wr_c = 1'b1; waddr_c = {1'b0, t};
      end
      if (!(mod_d[M_LALT] | mod_d[M_RALT]) && cnt_q != 2'd0) begin
        ch_d = alt_q[7:0];
        alt_d = 10'd0;
        cnt_d = 2'd0;
        altdone_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q <= 1'b0; num_q <= 1'b1; scroll_q <= 1'b0;
      mod_q <= '0; ext_q <= 1'b0; alt_q <= '0; cnt_q <= '0;
      s1_valid_q <= 1'b0;
      vld_q <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        caps_q <= caps_d; num_q <= num_d; scroll_q <= scroll_d;
        mod_q <= mod_d; ext_q <= ext_d; alt_q <= alt_d; cnt_q <= cnt_d;
        if (wr_c) begin
          vld_q[AW'(waddr_c)] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q      <= ch_d;
      altdone_q <= altdone_d;
      led_q     <= led_d;
      query_q   <= operation_i;
      vld_rd_q  <= vld_q[AW'(key_index_i)];
    end
  end

  scd1_ram #(
    .WIDTH (1),
    .DEPTH (KEY_MAP_DEPTH)
  ) u_key_map (
    .clk_i   (clk_i),
    .we_i    (accept & wr_c),
    .waddr_i (AW'(waddr_c)),
    .wdata_i (wdata_c),
    .re_i    (accept & operation_i),
    .raddr_i (AW'(key_index_i)),
    .rdata_o (rdata)
  );

  assign out_valid_o      = s1_valid_q;
  assign char_code_o      = ch_q;
  assign alt_entry_done_o = altdone_q;
  assign led_update_o     = led_q;
  assign led_mask_o       = {caps_q, num_q, scroll_q};
  assign key_is_down_o    = query_q & vld_rd_q & rdata;

endmodule

@@ sv/scd1_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scd1_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/scd1_checker.sv @@
// Port-level checker for the scan code decoder, bound to the top level.
module scd1_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_code_o,
  input logic       alt_entry_done_o,
  input logic       led_update_o,
  input logic       key_is_down_o
);

  a_accept_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(char_code_o))
    else $error("stalled result changed");

  a_query_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_is_down_o |-> char_code_o == 8'h00 && !led_update_o
    && !alt_entry_done_o)
    else $error("query result carries scan fields");

  a_alt_no_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alt_entry_done_o |-> !led_update_o)
    else $error("alt entry with LED update");

endmodule

bind scan_code_set1_decoder_top scd1_checker u_scd1_checker (.*);
